// ----- rtl/core/dmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the direct-mapped cache tag store with
// saturating hit and miss counters.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int ADDR_W        = 16;
    localparam int IDX_FIELD_W   = 7;
    localparam int IDX_FIELD_N   = 1 << IDX_FIELD_W;
    localparam int TAG_W         = ADDR_W - IDX_FIELD_W;
    localparam int OFFSET_W      = 3;
    localparam int CNT_W         = 32;
    localparam int NUM_CNT       = 6;
    localparam int NUM_LINES_DEF = 128;

    localparam logic [OFFSET_W-1:0] MAX_OFFSET = 3'd6;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Counter slots
    localparam int CNT_RD      = 0;
    localparam int CNT_WR      = 1;
    localparam int CNT_RD_HIT  = 2;
    localparam int CNT_RD_MISS = 3;
    localparam int CNT_WR_HIT  = 4;
    localparam int CNT_WR_MISS = 5;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] rd_total;
        logic [CNT_W-1:0] wr_total;
        logic [CNT_W-1:0] read_hits;
        logic [CNT_W-1:0] read_misses;
        logic [CNT_W-1:0] write_hits;
        logic [CNT_W-1:0] write_misses;
    } res_t;

    typedef struct packed {
        logic load;
        logic update;
        logic clear;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

// ----- rtl/core/dmc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: accepts an access, runs the lookup cycle, strobes the result; clears on a config write while idle.
// ----------------------------------------------------------------------------
module dmc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cfg_valid,
    output logic          busy,
    output logic          cfg_ready,
    output logic          done,
    output dmc_pkg::cmd_t cmd
);
    import dmc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_LOOK);
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign done       = done_reg;
    assign cmd.load   = start && (state_reg == ST_IDLE);
    assign cmd.update = (state_reg == ST_LOOK);
    assign cmd.clear  = cfg_valid && (state_reg == ST_IDLE);

endmodule

// ----- rtl/core/dmc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_datapath
// Tag memory, valid bits, offset register and saturating access counters.
// ----------------------------------------------------------------------------
module dmc_datapath #(
    parameter int NUM_LINES = dmc_pkg::NUM_LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dmc_pkg::cmd_t                   cmd,
    input  dmc_pkg::req_t                   req,
    input  logic [dmc_pkg::OFFSET_W-1:0]    cfg_data,
    output dmc_pkg::res_t                   result
);
    import dmc_pkg::*;

    localparam int IW = $clog2(NUM_LINES);

    logic [TAG_W-1:0]       tag_mem [NUM_LINES];
    logic [TAG_W-1:0]       tag_q;
    logic [NUM_LINES-1:0]   valid_reg;
    logic [NUM_LINES-1:0]   valid_next;
    logic [OFFSET_W-1:0]    offset_reg;
    logic [CNT_W-1:0]       cnt_reg  [NUM_CNT];
    logic [CNT_W-1:0]       cnt_next [NUM_CNT];
    logic                   hit_reg;
    logic                   hit_next;
    logic                   op_reg;
    logic [IW-1:0]          idx_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [IW-1:0]          line_map [IDX_FIELD_N];
    logic [OFFSET_W-1:0]    shift;
    logic [IDX_FIELD_W-1:0] field;
    logic [IW-1:0]          req_idx;
    logic                   hit;

    // Index field to line, wrapping by NUM_LINES
    for (genvar g = 0; g < IDX_FIELD_N; g++)
    begin : g_map
        assign line_map[g] = IW'(g % NUM_LINES);
    end

    assign shift   = (offset_reg > MAX_OFFSET) ? MAX_OFFSET : offset_reg;
    assign field   = req.address[IDX_FIELD_W-1:0] >> shift;
    assign req_idx = line_map[field];

    // Tag read on accept, fill on miss in the lookup cycle
    always_ff @(posedge clk)
    begin
        if (cmd.update && !hit)
        begin
            tag_mem[idx_reg] <= tag_reg;
        end
        if (cmd.load)
        begin
            tag_q <= tag_mem[req_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.op;
            idx_reg <= req_idx;
            tag_reg <= req.address[ADDR_W-1:IDX_FIELD_W];
        end
    end

    assign hit = valid_reg[idx_reg] && (tag_q == tag_reg);

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (cmd.clear)
        begin
            valid_next = '0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_next[i] = '0;
            end
        end
        else if (cmd.update)
        begin
            valid_next[idx_reg] = 1'b1;
            hit_next            = hit;
            if (op_reg == OP_WRITE)
            begin
                cnt_next[CNT_WR] = sat_inc(cnt_reg[CNT_WR]);
                if (hit)
                begin
                    cnt_next[CNT_WR_HIT] = sat_inc(cnt_reg[CNT_WR_HIT]);
                end
                else
                begin
                    cnt_next[CNT_WR_MISS] = sat_inc(cnt_reg[CNT_WR_MISS]);
                end
            end
            else
            begin
                cnt_next[CNT_RD] = sat_inc(cnt_reg[CNT_RD]);
                if (hit)
                begin
                    cnt_next[CNT_RD_HIT] = sat_inc(cnt_reg[CNT_RD_HIT]);
                end
                else
                begin
                    cnt_next[CNT_RD_MISS] = sat_inc(cnt_reg[CNT_RD_MISS]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            offset_reg <= '0;
            hit_reg    <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            if (cmd.clear)
            begin
                offset_reg <= cfg_data;
            end
        end
    end

    assign result.hit          = hit_reg;
    assign result.rd_total     = cnt_reg[CNT_RD];
    assign result.wr_total     = cnt_reg[CNT_WR];
    assign result.read_hits    = cnt_reg[CNT_RD_HIT];
    assign result.read_misses  = cnt_reg[CNT_RD_MISS];
    assign result.write_hits   = cnt_reg[CNT_WR_HIT];
    assign result.write_misses = cnt_reg[CNT_WR_MISS];

endmodule

// ----- rtl/core/direct_mapped_cache_hit_counter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_counter_top
// Direct-mapped cache tag store with saturating read/write hit/miss counters.
// ----------------------------------------------------------------------------
//  channel   handshake                 word
//  --------  ------------------------  --------------------------------------
//  request   start, busy               req (op, address)
//  result    done (one-cycle strobe)   result (hit, six counters)
//  config    cfg_valid, cfg_ready      cfg_data (offset width)
//
//  An access is taken when start is high and busy is low. The tag memory is
//  read at that edge, the next cycle compares, fills on a miss and counts,
//  and done strobes the cycle after. Busy is high during the lookup, so a new
//  access is taken only once the lookup of the last one is over.
//  Reset clears valid bits, counters and the offset width; no clearing pass.
//  The receiver cannot stall; a config write also clears valid bits and
//  counters.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_counter_top #(
    parameter int NUM_LINES = dmc_pkg::NUM_LINES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  dmc_pkg::req_t                req,
    output logic                         done,
    output dmc_pkg::res_t                result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dmc_pkg::OFFSET_W-1:0] cfg_data
);
    import dmc_pkg::*;

    cmd_t cmd;

    dmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .cmd       (cmd)
    );

    dmc_datapath #(
        .NUM_LINES (NUM_LINES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .result   (result)
    );

    // Busy never stays high beyond the lookup cycle
    a_look_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("lookup held busy for more than one cycle");

    // Every strobe follows a lookup cycle
    a_done_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a lookup");

    // An access accepted without a config write strobes a result after its lookup
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_valid) |=> ##1 done)
        else $error("accepted access produced no result");

    // A config write clears the counters
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (result.rd_total == '0 && result.wr_total == '0))
        else $error("counters not cleared by config write");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the direct-mapped cache tag store with saturating access
// counters. A directed opening hits the corner addresses and both offset
// extremes. Random phases then walk through every offset width, mostly
// reusing a small set of blocks so that hits, conflicts and refills all
// happen. Each result is checked against a predictor that tracks the tag
// store and counters in step with every accepted access.
// ----------------------------------------------------------------------------
module tb;
    import dmc_pkg::*;

    // Tracks tags, valid bits and tallies; holds the expected result words
    class cache_tally_checker;
        logic [TAG_W-1:0] line_tag [NUM_LINES_DEF];
        bit               line_ok  [NUM_LINES_DEF];
        logic [CNT_W-1:0] tally    [NUM_CNT];
        logic [OFFSET_W-1:0] offset_width;
        res_t             expected_tallies [$];
        int               errors;

        function new();
            errors = 0;
            offset_width = '0;
            clear_lines();
        endfunction

        function void clear_lines();
            foreach (line_ok[i]) line_ok[i] = 1'b0;
            foreach (tally[i]) tally[i] = '0;
        endfunction

        function void load_offset(input logic [OFFSET_W-1:0] v);
            offset_width = v;
            clear_lines();
        endfunction

        function void bump(input int slot);
            if (tally[slot] != {CNT_W{1'b1}})
                tally[slot] = tally[slot] + CNT_W'(1);
        endfunction

        function void note_access(input req_t r);
            int               shift;
            int               line;
            logic [TAG_W-1:0] tag;
            bit               hit;
            res_t             e;
            shift = (offset_width > MAX_OFFSET) ? int'(MAX_OFFSET) : int'(offset_width);
            line  = (int'(r.address[IDX_FIELD_W-1:0]) >> shift) % NUM_LINES_DEF;
            tag   = r.address[ADDR_W-1:IDX_FIELD_W];
            hit   = line_ok[line] && (line_tag[line] == tag);
            if (!hit)
            begin
                line_tag[line] = tag;
                line_ok[line]  = 1'b1;
            end
            if (r.op == OP_WRITE)
            begin
                bump(CNT_WR);
                bump(hit ? CNT_WR_HIT : CNT_WR_MISS);
            end
            else
            begin
                bump(CNT_RD);
                bump(hit ? CNT_RD_HIT : CNT_RD_MISS);
            end
            e.hit          = hit;
            e.rd_total     = tally[CNT_RD];
            e.wr_total     = tally[CNT_WR];
            e.read_hits    = tally[CNT_RD_HIT];
            e.read_misses  = tally[CNT_RD_MISS];
            e.write_hits   = tally[CNT_WR_HIT];
            e.write_misses = tally[CNT_WR_MISS];
            expected_tallies.push_back(e);
        endfunction

        function void check_tally(input res_t got);
            res_t             e;
            logic [CNT_W-1:0] gv [6];
            logic [CNT_W-1:0] ev [6];
            string            field [6] = '{"rd_total", "wr_total", "read_hits",
                                            "read_misses", "write_hits", "write_misses"};
            if (expected_tallies.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = expected_tallies.pop_front();
            if (got.hit !== e.hit)
            begin
                $error("hit: expected %0d, got %0d", e.hit, got.hit);
                errors++;
            end
            gv = '{got.rd_total, got.wr_total, got.read_hits,
                   got.read_misses, got.write_hits, got.write_misses};
            ev = '{e.rd_total, e.wr_total, e.read_hits,
                   e.read_misses, e.write_hits, e.write_misses};
            foreach (gv[i])
                if (gv[i] !== ev[i])
                begin
                    $error("%s: expected %0d, got %0d", field[i], ev[i], gv[i]);
                    errors++;
                end
        endfunction

        function int pending();
            return expected_tallies.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    req_t                req;
    logic                done;
    res_t                result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [OFFSET_W-1:0] cfg_data;

    cache_tally_checker sb = new();

    direct_mapped_cache_hit_counter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_tally(result);

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic issue_access(input logic op, input logic [ADDR_W-1:0] addr);
        req_t r;
        r.op      = op;
        r.address = addr;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        sb.note_access(r);
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct)
            idle_cycle();
    endtask

    // Hold off until every expected word has come, then let the pipe settle
    task automatic drain_results();
        int guard;
        guard = 0;
        idle_cycle();
        while (sb.pending() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.load_offset(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [OFFSET_W-1:0] offs, input int n_items,
                                input int gap_pct);
        logic [ADDR_W-1:0] pool [12];
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] low_mask;
        int                shift;
        int                pick;
        shift    = (offs > MAX_OFFSET) ? int'(MAX_OFFSET) : int'(offs);
        low_mask = ADDR_W'((1 << shift) - 1);
        foreach (pool[i]) pool[i] = ADDR_W'($urandom);
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                drain_results();
            pick = $urandom_range(99);
            addr = pool[$urandom_range(11)];
            if (pick < 70)
                addr = addr ^ (ADDR_W'($urandom) & low_mask);  // same block: hit
            else if (pick < 85)
                addr = {TAG_W'($urandom), addr[IDX_FIELD_W-1:0]};  // conflict
            else
                addr = ADDR_W'($urandom);
            sender_gap(gap_pct);
            issue_access(logic'($urandom_range(1)), addr);
        end
    endtask

    initial
    begin
        logic [OFFSET_W-1:0] phase_offs [8];
        int                  gap_pct;
        phase_offs = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4};
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, offset width zero from reset
        issue_access(OP_READ,  16'h0000);
        issue_access(OP_READ,  16'h0000);
        issue_access(OP_WRITE, 16'h0000);
        issue_access(OP_WRITE, 16'hFFFF);
        issue_access(OP_READ,  16'hFFFF);
        issue_access(OP_READ,  16'hFF80);
        issue_access(OP_READ,  16'h0000);
        issue_access(OP_WRITE, 16'h007F);
        issue_access(OP_WRITE, 16'h8040);
        issue_access(OP_READ,  16'h8040);
        issue_access(OP_WRITE, 16'h7FBF);
        issue_access(OP_READ,  16'h0001);
        issue_access(OP_WRITE, 16'h0001);
        issue_access(OP_READ,  16'h5555);
        issue_access(OP_WRITE, 16'hAAAA);

        // Width seven looks up as six: only two lines in use
        write_offset(3'd7);
        issue_access(OP_READ,  16'h0000);
        issue_access(OP_READ,  16'h003F);
        issue_access(OP_WRITE, 16'h0040);
        issue_access(OP_WRITE, 16'hFFC0);
        issue_access(OP_READ,  16'h007F);
        issue_access(OP_READ,  16'hFF80);

        for (int p = 0; p < 8; p++)
        begin
            gap_pct = (p < 3) ? 22 : (p < 6) ? 81 : 0;
            write_offset(phase_offs[p]);
            random_phase(phase_offs[p], 166, gap_pct);
        end

        drain_results();
        if (sb.pending() != 0)
        begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dmc_pkg.sv
rtl/core/dmc_ctrl.sv
rtl/core/dmc_datapath.sv
rtl/core/direct_mapped_cache_hit_counter_top.sv
bench/tb.sv
